// ----- rtl/cu_pkg.sv -----
// Shared constants and control types for the combination unranking block.
`timescale 1ns / 1ps

package cu_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int M_W        = $clog2(MAX_LENGTH);
    localparam int TBL_DEPTH  = MAX_LENGTH * MAX_LENGTH;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int DATA_W     = 64;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 8;

    localparam logic [DATA_W-1:0]    BINOM_SAT  = 64'h3f3f_3f3f_3f3f_3f3f;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 8'd1;

    typedef struct packed {
        logic fill_rd;
        logic fill_wr;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic left_zero;
    } t_sts;

endpackage

// ----- rtl/cu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cu_dp.sv -----
// Datapath: configuration registers, binomial table fill and per-position unranking step.
`timescale 1ns / 1ps

module cu_dp import cu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [DATA_W-1:0]    i_rank,
    output logic [DATA_W-1:0]    o_pattern,
    output logic                 o_out_of_range
);

    logic [CFG_W-1:0]  r_length;
    logic [CFG_W-1:0]  r_weight;

    // table fill sweep
    logic [M_W-1:0]    r_fr;
    logic [M_W-1:0]    r_fc;
    logic [DATA_W-1:0] r_prev;

    // unranking state
    logic [DATA_W-1:0] r_rest;
    logic [CFG_W-1:0]  r_k;
    logic [M_W-1:0]    r_m;
    logic [M_W-1:0]    r_pos;
    logic [CFG_W-1:0]  r_left;
    logic              r_zero;
    logic [DATA_W-1:0] r_pat;

    logic [DATA_W-1:0] r_out_pat;
    logic              r_out_oor;

    logic              ram_we;
    logic [TBL_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [TBL_AW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [DATA_W-1:0] fill_sum;
    logic [CFG_W-1:0]  n_eff;
    logic [CFG_W-1:0]  n_eff_m1;
    logic [DATA_W-1:0] coef;
    logic              take;
    logic [DATA_W-1:0] n_rest;
    logic [CFG_W-1:0]  n_k;
    logic [M_W-1:0]    m_next;
    logic              bad;

    assign n_eff    = (r_length > CFG_W'(MAX_LENGTH)) ? CFG_W'(MAX_LENGTH) : r_length;
    assign n_eff_m1 = n_eff - CFG_W'(1);

    assign fill_sum = ram_rdata + r_prev;

    // a weight above the row reads as a zero coefficient
    assign coef   = r_zero ? '0 : ram_rdata;
    assign take   = (r_k != '0) && (coef <= r_rest);
    assign n_rest = take ? (r_rest - coef) : r_rest;
    assign n_k    = r_k - CFG_W'(take);
    assign m_next = r_m - M_W'(1);

    assign bad = (r_k != '0) || (r_rest != '0);

    always_comb begin
        ram_we    = i_cmd.fill_wr;
        ram_waddr = {r_fr, r_fc};
        if ((r_fc == '0) || (r_fc == r_fr)) begin
            ram_wdata = DATA_W'(1);
        end else if (fill_sum < BINOM_SAT) begin
            ram_wdata = fill_sum;
        end else begin
            ram_wdata = BINOM_SAT;
        end

        if (i_cmd.fill_rd) begin
            ram_raddr = {r_fr - M_W'(1), r_fc};
        end else if (i_cmd.start) begin
            ram_raddr = {n_eff_m1[M_W-1:0], r_weight[M_W-1:0]};
        end else begin
            ram_raddr = {m_next, n_k[M_W-1:0]};
        end
    end

    cu_ram #(
        .WIDTH(DATA_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= CFG_W'(MAX_LENGTH);
            r_weight <= '0;
            r_fr     <= '0;
            r_fc     <= '0;
            r_left   <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_LENGTH)) begin
                r_length <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_WEIGHT)) begin
                r_weight <= i_cfg_data;
            end
            if (i_cmd.fill_wr) begin
                if (r_fc == r_fr) begin
                    r_fc <= '0;
                    r_fr <= r_fr + M_W'(1);
                end else begin
                    r_fc <= r_fc + M_W'(1);
                end
            end
            if (i_cmd.start) begin
                r_left <= n_eff;
            end else if (i_cmd.step) begin
                r_left <= r_left - CFG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_prev <= ram_rdata;
        end
        if (i_cmd.start) begin
            r_rest <= i_rank;
            r_k    <= r_weight;
            r_m    <= n_eff_m1[M_W-1:0];
            r_pos  <= '0;
            r_zero <= r_weight > n_eff_m1;
            r_pat  <= '0;
        end else if (i_cmd.step) begin
            r_rest <= n_rest;
            r_k    <= n_k;
            r_m    <= m_next;
            r_pos  <= r_pos + M_W'(1);
            r_zero <= n_k > {1'b0, m_next};
            r_pat  <= r_pat | (DATA_W'(take) << r_pos);
        end
        if (i_cmd.load_out) begin
            r_out_pat <= bad ? '0 : r_pat;
            r_out_oor <= bad;
        end
    end

    assign o_sts.fill_last = (r_fr == M_W'(MAX_LENGTH - 1)) && (r_fc == r_fr);
    assign o_sts.left_zero = (r_left == '0);

    assign o_pattern      = r_out_pat;
    assign o_out_of_range = r_out_oor;

endmodule

// ----- rtl/cu_ctrl.sv -----
// Controller: table fill sequencing, item acceptance, step issue and output handshake.
`timescale 1ns / 1ps

module cu_ctrl import cu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rank_valid,
    output logic o_rank_stall,
    output logic o_res_valid,
    input  logic i_res_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_FILL_RD,
        S_FILL_WR,
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_res_stall;

    always_comb begin
        o_cmd          = '0;
        o_cmd.fill_rd  = (r_state == S_FILL_RD);
        o_cmd.fill_wr  = (r_state == S_FILL_WR);
        o_cmd.start    = (r_state == S_IDLE) && i_rank_valid;
        o_cmd.step     = (r_state == S_RUN) && !i_sts.left_zero;
        o_cmd.load_out = (r_state == S_RUN) && i_sts.left_zero && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL_RD;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_FILL_RD: begin
                    r_state <= S_FILL_WR;
                end
                S_FILL_WR: begin
                    r_state <= i_sts.fill_last ? S_IDLE : S_FILL_RD;
                end
                S_IDLE: begin
                    if (i_rank_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rank_stall = (r_state != S_IDLE);
    assign o_res_valid  = r_out_valid;

endmodule

// ----- rtl/combination_unrank.sv -----
// Top level of the combination unranking block.
`timescale 1ns / 1ps

// Turns a rank into the length-n, weight-k bit pattern at that place in
// lexicographic order (bit 0 is the first position); n and k are the
// configuration registers length_bits (index 0) and ones_weight (index 1),
// written over the cfg port, which is always ready. After reset the block
// builds its saturated Pascal table in a 4096-entry RAM, a read and a write per
// entry of the lower triangle, while the rank port stalls. Each rank then
// passes through accept, one table read and compare/subtract per position,
// and result load, which waits while the previous result is still held.
// The result sits in an output register, so the next rank is accepted while
// the previous result waits to be taken. out_of_range flags a rank at or above
// C(n,k) or a weight above the length, with the pattern forced to zero.
module combination_unrank import cu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rank_valid,
    output logic                 o_rank_stall,
    input  logic [DATA_W-1:0]    i_rank,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output logic [DATA_W-1:0]    o_pattern,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    cu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rank_valid(i_rank_valid),
        .o_rank_stall(o_rank_stall),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rank        (i_rank),
        .o_pattern     (o_pattern),
        .o_out_of_range(o_out_of_range)
    );

endmodule

// ----- tb/tb_combination_unrank.sv -----
// Self-checking testbench for the combination unranking block.
`timescale 1ns / 1ps

module tb_combination_unrank;
    import cu_pkg::*;

    localparam int RANDOM_ITEMS    = 1600;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PRESSURE_PHASE  = 6;
    localparam int TAIL_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int REPORT_CAP      = 100;

    typedef struct packed {
        logic [DATA_W-1:0] pattern;
        logic              out_of_range;
    } unrank_result_t;

    typedef struct {
        logic [CFG_W-1:0]  len;
        logic [CFG_W-1:0]  wt;
        logic [DATA_W-1:0] rank;
    } directed_case_t;

    class unrank_scoreboard;
        logic [DATA_W-1:0] pascal [0:MAX_LENGTH-1][0:MAX_LENGTH];
        logic [CFG_W-1:0]  length_bits;
        logic [CFG_W-1:0]  ones_weight;
        unrank_result_t    expected_patterns[$];
        int                mismatches;
        int                checked;
        int                flagged;

        function new();
            logic [DATA_W:0] sum;
            for (int r = 0; r < MAX_LENGTH; r++) begin
                for (int c = 0; c <= MAX_LENGTH; c++) pascal[r][c] = '0;
                pascal[r][0] = DATA_W'(1);
                for (int c = 1; c <= r; c++) begin
                    sum = {1'b0, pascal[r-1][c]} + {1'b0, pascal[r-1][c-1]};
                    pascal[r][c] = (sum < BINOM_SAT) ? sum[DATA_W-1:0] : BINOM_SAT;
                end
            end
            length_bits = 7'd64;
            ones_weight = 7'd0;
        endfunction

        function logic [DATA_W-1:0] binom(int m, int k);
            if (m < 0 || m >= MAX_LENGTH || k < 0 || k > m) return '0;
            return pascal[m][k];
        endfunction

        // Number of patterns for a setting; rows past the table are built on the fly.
        function logic [DATA_W-1:0] pattern_count(int n, int k);
            logic [DATA_W:0] sum;
            if (n > MAX_LENGTH) n = MAX_LENGTH;
            if (k > n) return '0;
            if (n == 0) return DATA_W'(1);
            sum = {1'b0, binom(n - 1, k)} + {1'b0, binom(n - 1, k - 1)};
            return (sum < BINOM_SAT) ? sum[DATA_W-1:0] : BINOM_SAT;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_LENGTH)
                length_bits = data;
            else if (idx == CFG_WEIGHT)
                ones_weight = data;
        endfunction

        function unrank_result_t unrank(logic [DATA_W-1:0] rank);
            unrank_result_t    res;
            logic [DATA_W-1:0] rest;
            logic [DATA_W-1:0] coeff;
            int                n;
            int                k;
            n           = (length_bits > MAX_LENGTH) ? MAX_LENGTH : int'(length_bits);
            k           = int'(ones_weight);
            rest        = rank;
            res.pattern = '0;
            for (int i = 0; i < n; i++) begin
                coeff = binom(n - i - 1, k);
                // a spent weight leaves the rank in place, so any remainder ends flagged
                if (coeff <= rest && k != 0) begin
                    rest           = rest - coeff;
                    k              = k - 1;
                    res.pattern[i] = 1'b1;
                end
            end
            res.out_of_range = (k != 0) || (rest != 0);
            if (res.out_of_range) res.pattern = '0;
            return res;
        endfunction

        function void note_rank(logic [DATA_W-1:0] rank);
            expected_patterns.insert(expected_patterns.size(), unrank(rank));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [DATA_W-1:0] pattern, logic out_of_range);
            unrank_result_t want;
            if (expected_patterns.size() == 0) begin
                report_mismatch($sformatf("result with none pending, pattern=%h oor=%b",
                                          pattern, out_of_range));
                return;
            end
            want = expected_patterns.pop_front();
            checked++;
            if (want.out_of_range) flagged++;
            if (pattern !== want.pattern)
                report_mismatch($sformatf("result %0d pattern got %h want %h",
                                          checked, pattern, want.pattern));
            if (out_of_range !== want.out_of_range)
                report_mismatch($sformatf("result %0d out_of_range got %b want %b",
                                          checked, out_of_range, want.out_of_range));
        endtask
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 rank_valid   = 1'b0;
    logic                 rank_stall;
    logic [DATA_W-1:0]    rank         = '0;
    logic                 res_valid;
    logic                 res_stall    = 1'b0;
    logic [DATA_W-1:0]    pattern;
    logic                 out_of_range;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    unrank_scoreboard sb;
    int               idle_cycles    = 0;
    int               n_configs      = 0;
    bit               pressure_req   = 1'b0;
    bit               pressure_active = 1'b0;

    combination_unrank i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rank_valid   (rank_valid),
        .o_rank_stall   (rank_stall),
        .i_rank         (rank),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_pattern      (pattern),
        .o_out_of_range (out_of_range),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [DATA_W-1:0] pick_rank(logic [DATA_W-1:0] count);
        logic [DATA_W-1:0] wide;
        int                r;
        wide = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        if (count == 0 || r < 10) return wide;
        if (r < 75) return wide % count;
        if (r < 85) return count - 1;
        if (r < 90) return '0;
        return count + wide[3:0];
    endfunction

    task automatic send_rank(input logic [DATA_W-1:0] value, input int gap);
        rank_valid <= 1'b1;
        rank       <= value;
        do @(posedge clk); while (rank_stall);
        sb.note_rank(value);
        if (gap > 0) begin
            rank_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_config(idx, data);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic program_cfg(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] wt,
                               input bit spare);
        if (spare)
            write_cfg(CFG_IDX_W'($urandom_range(CFG_WEIGHT + 1, 2 ** CFG_IDX_W - 1)),
                      CFG_W'($urandom), 1'b0);
        write_cfg(CFG_LENGTH, len, 1'b0);
        write_cfg(CFG_WEIGHT, wt, 1'b1);
        n_configs++;
    endtask

    // Settle the block before touching its registers.
    task automatic drain();
        if (rank_valid) rank_valid <= 1'b0;
        while (sb.expected_patterns.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (res_valid && !res_stall) sb.check_result(pattern, out_of_range);
            if ((rank_valid && !rank_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("combination_unrank regression: fail");
        $finish;
    end

    // Result side: random stall runs, one long hold-off on request.
    initial begin
        int open_len;
        int hold_len;
        int r;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (pressure_req) begin
                res_stall       <= 1'b1;
                pressure_active = 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                pressure_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      open_len = $urandom_range(1, 4);
                else if (r < 90) open_len = $urandom_range(5, 20);
                else             open_len = $urandom_range(100, 300);
                r = $urandom_range(0, 99);
                if (r < 75)      hold_len = $urandom_range(1, 3);
                else if (r < 95) hold_len = $urandom_range(4, 12);
                else             hold_len = $urandom_range(20, 60);
                res_stall <= 1'b0;
                repeat (open_len) @(posedge clk);
                res_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
            end
        end
    end

    initial begin
        directed_case_t    directed_q[$];
        logic [CFG_W-1:0]  cur_len;
        logic [CFG_W-1:0]  cur_wt;
        logic [CFG_W-1:0]  len;
        logic [CFG_W-1:0]  wt;
        logic [DATA_W-1:0] count;
        int                n_random;
        int                phase_no;
        int                per_phase;
        int                eff;
        int                r;
        bit                calm;
        bit                pressure;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting first, then weight exhausted, leftover rank, empty
        // pattern, oversize length and weight
        directed_q.insert(directed_q.size(), '{7'd64, 7'd0, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd0, 64'd1});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd0, '1});
        count = sb.pattern_count(64, 32);
        directed_q.insert(directed_q.size(), '{7'd64, 7'd32, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd32, count - 1});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd32, count});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd32, '1});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd64, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd64, 7'd64, 64'd1});
        directed_q.insert(directed_q.size(), '{7'd0, 7'd0, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd0, 7'd0, 64'd1});
        directed_q.insert(directed_q.size(), '{7'd0, 7'd1, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd5, 7'd7, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd100, 7'd1, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd100, 7'd1, 64'd63});
        directed_q.insert(directed_q.size(), '{7'd100, 7'd1, 64'd64});
        directed_q.insert(directed_q.size(), '{7'd127, 7'd64, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd10, 7'd100, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd3, 7'd127, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd1, 7'd1, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd1, 7'd1, 64'd1});
        directed_q.insert(directed_q.size(), '{7'd1, 7'd0, 64'd0});
        directed_q.insert(directed_q.size(), '{7'd20, 7'd10, sb.pattern_count(20, 10) - 1});

        cur_len = 7'd64;
        cur_wt  = 7'd0;
        foreach (directed_q[i]) begin
            if (directed_q[i].len != cur_len || directed_q[i].wt != cur_wt) begin
                drain();
                program_cfg(directed_q[i].len, directed_q[i].wt, n_configs == 0);
                cur_len = directed_q[i].len;
                cur_wt  = directed_q[i].wt;
            end
            send_rank(directed_q[i].rank, pick_gap());
        end

        n_random = 0;
        phase_no = 0;
        while (n_random < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30)      len = CFG_W'($urandom_range(1, 8));
            else if (r < 80) len = CFG_W'($urandom_range(9, 63));
            else if (r < 90) len = 7'd64;
            else if (r < 95) len = CFG_W'($urandom_range(65, 127));
            else             len = 7'd0;
            eff = (len > MAX_LENGTH) ? MAX_LENGTH : int'(len);
            r = $urandom_range(0, 99);
            if (r < 80)      wt = CFG_W'($urandom_range(0, eff));
            else if (r < 85) wt = 7'd0;
            else if (r < 90) wt = CFG_W'(eff);
            else             wt = CFG_W'($urandom_range(0, 127));

            drain();
            program_cfg(len, wt, $urandom_range(0, 9) == 0);
            count     = sb.pattern_count(len, wt);
            calm      = ($urandom_range(0, 5) == 0);
            pressure  = (phase_no == PRESSURE_PHASE);
            per_phase = pressure ? 40 : $urandom_range(20, 60);

            // keep offering back to back while the result side is held off
            if (pressure) begin
                pressure_req = 1'b1;
                wait (pressure_active);
            end
            for (int j = 0; j < per_phase; j++) begin
                send_rank(pick_rank(count), (calm || pressure) ? 0 : pick_gap());
                n_random++;
            end
            phase_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_patterns.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_patterns.size()));
        $display("checked %0d unranked patterns (%0d flagged out of range) over %0d settings",
                 sb.checked, sb.flagged, n_configs);
        $display("lengths and weights swept 0..127, result side held off once for %0d cycles",
                 PRESSURE_CYCLES);
        if (sb.mismatches == 0)
            $display("combination_unrank regression: pass");
        else
            $display("combination_unrank regression: fail");
        $finish;
    end

endmodule
